[hdl/srl_pkg.sv]
// shared constants, operation codes and controller/datapath command types
package srl_pkg;

    localparam int DEF_TABLE_DEPTH    = 1024;
    localparam int DEF_POSITION_WIDTH = 32;

    localparam int OP_W   = 2;
    localparam int SYM_W  = 8;
    localparam int QPOS_W = 32;
    localparam int REC_W  = 11;

    localparam logic [SYM_W-1:0] SEP_CODE_RESET = 8'hFF;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic append;
        logic restart;
        logic load;
        logic finish_trivial;
        logic read;
        logic step;
        logic finish_search;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic past_end;
        logic search_end;
    } t_dp_status;

endpackage

[hdl/separator_record_lookup_unit.sv]
// top level of the separator record lookup unit
//
// usage
// - input beat: start high while busy is low; operation selects append of
//   i_symbol, query of i_query_position, or restart (code 3 is ignored)
// - append: counts the symbol and, when it equals the separator code, stores its
//   position in the sorted table unless full; done in the accept cycle, busy stays low
// - restart: empties table, clears counters and overflow flag in the accept cycle;
//   the separator code is kept
// - query: binary search in the table memory after a check state, with a
//   registered read and a compare per step; busy drops in the same cycle as
//   the strobe rises, so the next beat can be taken while the strobe is high
// - result beat: o_result_valid high for exactly one cycle with record
//   number, not-found flag and sticky table overflow flag; the receiver
//   cannot stall, so nothing waits on it
// - configuration: i_cfg_wr_en writes i_cfg_wr_data to the separator code;
//   the user must write it only while the unit is idle, which is not enforced
// - reset (synchronous, active low): empty table, zero counters, separator
//   code 255; busy is held high while reset is asserted
module separator_record_lookup_unit #(
    parameter int TABLE_DEPTH    = srl_pkg::DEF_TABLE_DEPTH,
    parameter int POSITION_WIDTH = srl_pkg::DEF_POSITION_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [srl_pkg::OP_W-1:0]      i_operation,
    input  logic [srl_pkg::SYM_W-1:0]     i_symbol,
    input  logic [srl_pkg::QPOS_W-1:0]    i_query_position,
    // configuration write
    input  logic                          i_cfg_wr_en,
    input  logic [srl_pkg::SYM_W-1:0]     i_cfg_wr_data,
    // result channel
    output logic                          o_result_valid,
    output logic [srl_pkg::REC_W-1:0]     o_record_number,
    output logic                          o_not_found,
    output logic                          o_table_overflow
);

    // control and status between sequencer and datapath
    srl_pkg::t_dp_cmd    dp_cmd;
    srl_pkg::t_dp_status dp_status;

    // sequencer: accepts beats and steps the search
    srl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .busy        (busy)
    );

    // datapath: table memory, counters, search bounds, result registers
    srl_dpath #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_symbol         (i_symbol),
        .i_query_position (i_query_position),
        .o_result_valid   (o_result_valid),
        .o_record_number  (o_record_number),
        .o_not_found      (o_not_found),
        .o_table_overflow (o_table_overflow)
    );

endmodule

[hdl/srl_ctrl.sv]
// sequencing state machine for appends, restarts and the binary search
module srl_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [srl_pkg::OP_W-1:0]    i_operation,
    input  srl_pkg::t_dp_status         i_status,
    output srl_pkg::t_dp_cmd            o_cmd,
    output logic                        busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_CMP   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign busy   = (r_state != ST_IDLE) || !i_rst_n;
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_operation)
                        srl_pkg::OP_APPEND: begin
                            o_cmd.append = 1'b1;
                        end
                        srl_pkg::OP_QUERY: begin
                            o_cmd.load = 1'b1;
                            n_state    = ST_CHECK;
                        end
                        srl_pkg::OP_RESTART: begin
                            o_cmd.restart = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                // empty table or past the end: answer without searching
                if (i_status.count_zero || i_status.past_end) begin
                    o_cmd.finish_trivial = 1'b1;
                    n_state              = ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.step = 1'b1;
                if (i_status.search_end) begin
                    o_cmd.finish_search = 1'b1;
                    n_state             = ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/srl_dpath.sv]
// separator table memory, counters, search bounds and result registers
module srl_dpath #(
    parameter int TABLE_DEPTH    = srl_pkg::DEF_TABLE_DEPTH,
    parameter int POSITION_WIDTH = srl_pkg::DEF_POSITION_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srl_pkg::t_dp_cmd              i_cmd,
    output srl_pkg::t_dp_status           o_status,
    input  logic                          i_cfg_wr_en,
    input  logic [srl_pkg::SYM_W-1:0]     i_cfg_wr_data,
    input  logic [srl_pkg::SYM_W-1:0]     i_symbol,
    input  logic [srl_pkg::QPOS_W-1:0]    i_query_position,
    output logic                          o_result_valid,
    output logic [srl_pkg::REC_W-1:0]     o_record_number,
    output logic                          o_not_found,
    output logic                          o_table_overflow
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = POSITION_WIDTH;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [PW-1:0] POS_MAX = '1;

    logic [PW-1:0] r_table [TABLE_DEPTH];

    logic [srl_pkg::SYM_W-1:0] r_sep_code;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_seen, n_seen;
    logic          r_ovf, n_ovf;
    logic [PW-1:0] r_last;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic          r_valid, n_valid;
    logic [CW-1:0] r_rec, n_rec;
    logic          r_nf, n_nf;

    logic          is_sep;
    logic          store;
    logic [CW-1:0] mid;
    logic          cmp_lt;
    logic [CW-1:0] step_lo;
    logic [CW-1:0] step_hi;
    logic          past_end;

    assign is_sep   = (i_symbol == r_sep_code);
    assign store    = i_cmd.append && is_sep && (r_count < DEPTH_C);
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign cmp_lt   = (r_rd < r_pos);
    assign step_lo  = cmp_lt ? (mid + CW'(1)) : r_lo;
    assign step_hi  = cmp_lt ? r_hi : mid;
    assign past_end = (r_count != '0) && (r_pos > r_last) && (r_pos >= r_seen);

    assign o_status.count_zero = (r_count == '0);
    assign o_status.past_end   = past_end;
    assign o_status.search_end = (step_lo == step_hi);

    always_comb begin
        n_count = r_count;
        n_seen  = r_seen;
        n_ovf   = r_ovf;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_valid = 1'b0;
        n_rec   = r_rec;
        n_nf    = r_nf;
        if (i_cmd.restart) begin
            n_count = '0;
            n_seen  = '0;
            n_ovf   = 1'b0;
        end
        if (i_cmd.append) begin
            if (store) begin
                n_count = r_count + CW'(1);
            end else if (is_sep) begin
                n_ovf = 1'b1;
            end
            // position count saturates
            if (r_seen != POS_MAX) begin
                n_seen = r_seen + PW'(1);
            end
        end
        if (i_cmd.load) begin
            n_lo = '0;
            n_hi = r_count;
        end
        if (i_cmd.step) begin
            n_lo = step_lo;
            n_hi = step_hi;
        end
        if (i_cmd.finish_trivial) begin
            n_valid = 1'b1;
            n_rec   = '0;
            n_nf    = past_end;
        end
        if (i_cmd.finish_search) begin
            n_valid = 1'b1;
            n_rec   = step_lo;
            n_nf    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_code <= srl_pkg::SEP_CODE_RESET;
            r_count    <= '0;
            r_seen     <= '0;
            r_ovf      <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sep_code <= i_cfg_wr_data;
            end
            r_count <= n_count;
            r_seen  <= n_seen;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_last <= r_seen;
        end
        if (i_cmd.load) begin
            r_pos <= PW'(i_query_position);
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_rec <= n_rec;
        r_nf  <= n_nf;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_table[r_count[AW-1:0]] <= r_seen;
        end
        if (i_cmd.read) begin
            r_rd <= r_table[mid[AW-1:0]];
        end
    end

    assign o_result_valid   = r_valid;
    assign o_record_number  = srl_pkg::REC_W'(r_rec);
    assign o_not_found      = r_nf;
    assign o_table_overflow = r_ovf;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held longer than one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("separator count exceeds table depth");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.read |-> (r_lo < r_hi) && (r_hi <= r_count))
        else $error("table read issued with an empty search window");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf && !i_cmd.restart |=> r_ovf)
        else $error("overflow flag cleared without restart");

    a_nf_zero_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_nf |-> (r_rec == '0))
        else $error("not-found result carries a record number");

endmodule
